// File: hw/rtl/smvc_pkg.sv
package smvc_pkg;

	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned HOUR_BCD_W = 6;
	localparam int unsigned MIN_BCD_W = 7;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned MIN_W = 6;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
	localparam logic [MIN_W-1:0] MIN_LAST = 6'd59;

	localparam logic [LEVEL_W-1:0] CRIT_RESET = 7'd25;
	localparam logic [LEVEL_W-1:0] GOOD_RESET = 7'd70;
	localparam logic [HOUR_W-1:0] HOUR1_RESET = 5'd9;
	localparam logic [HOUR_W-1:0] HOUR2_RESET = 5'd15;

	typedef enum logic [1:0] {
		REQ_CHECK = 2'd0,
		REQ_MODE  = 2'd1,
		REQ_INC   = 2'd2,
		REQ_DEC   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_HOUR_ONE = 3'd1,
		MODE_HOUR_TWO = 3'd2,
		MODE_MIN_ONE  = 3'd3,
		MODE_MIN_TWO  = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CRITICAL = 1'b0,
		CFG_GOOD     = 1'b1
	} cfg_idx_t;

	// Event handed to the schedule block when the staged word is processed.
	typedef struct packed {
		logic fire;
		req_t req;
		logic [HOUR_BCD_W-1:0] hour_bcd;
		logic [MIN_BCD_W-1:0] minute_bcd;
	} sched_ev_t;

	// Status returned by the schedule block; mode and value reflect the state after the event.
	typedef struct packed {
		logic match;
		mode_t mode;
		logic [MIN_W-1:0] value;
	} sched_sts_t;

	// Binary to two BCD digits for values up to 59.
	function automatic logic [MIN_BCD_W-1:0] to_bcd(input logic [MIN_W-1:0] v);
		logic [2:0] tens;
		logic [MIN_W-1:0] rest;
		begin
			if (v >= 6'd50) begin
				tens = 3'd5;
				rest = v - 6'd50;
			end else if (v >= 6'd40) begin
				tens = 3'd4;
				rest = v - 6'd40;
			end else if (v >= 6'd30) begin
				tens = 3'd3;
				rest = v - 6'd30;
			end else if (v >= 6'd20) begin
				tens = 3'd2;
				rest = v - 6'd20;
			end else if (v >= 6'd10) begin
				tens = 3'd1;
				rest = v - 6'd10;
			end else begin
				tens = 3'd0;
				rest = v;
			end
			to_bcd = {tens, rest[3:0]};
		end
	endfunction

endpackage

// File: hw/rtl/smvc_pct.sv
module smvc_pct (
	input  logic [smvc_pkg::SAMPLE_W-1:0] sample,
	output logic [smvc_pkg::PCT_W-1:0]    pct
);

	// 100 * sample fits in 17 bits.
	logic [16:0] prod;
	logic [6:0]  q0;
	logic [10:0] rem;
	logic [6:0]  quot;

	// Dividing by 1024 first undershoots the true quotient by at most one, so the
	// remainder over 1023 stays below twice the divisor and one correction suffices.
	assign prod = {1'b0, sample, 6'b0} + {2'b0, sample, 5'b0} + {5'b0, sample, 2'b0};
	assign q0   = prod[16:10];
	assign rem  = {1'b0, prod[9:0]} + {4'b0, q0};
	assign quot = (rem >= 11'd1023) ? q0 + 7'd1 : q0;
	assign pct  = smvc_pkg::PCT_FULL - quot;

endmodule

// File: hw/rtl/smvc_sched.sv
module smvc_sched (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smvc_pkg::sched_ev_t    ev,
	output smvc_pkg::sched_sts_t   sts
);

	smvc_pkg::mode_t mode_q, mode_nxt;
	logic [smvc_pkg::HOUR_W-1:0] hour1_q, hour2_q, hour1_nxt, hour2_nxt;
	logic [smvc_pkg::MIN_W-1:0]  min1_q, min2_q, min1_nxt, min2_nxt;
	logic up, down;
	logic [smvc_pkg::MIN_BCD_W-1:0] h1_bcd, h2_bcd, m1_bcd, m2_bcd, hour_in;

	assign up   = ev.req == smvc_pkg::REQ_INC;
	assign down = ev.req == smvc_pkg::REQ_DEC;

	function automatic logic [smvc_pkg::HOUR_W-1:0] step_hour(
		input logic [smvc_pkg::HOUR_W-1:0] v, input logic inc);
		begin
			if (inc)
				step_hour = (v == smvc_pkg::HOUR_LAST) ? '0 : v + 5'd1;
			else
				step_hour = (v == '0) ? smvc_pkg::HOUR_LAST : v - 5'd1;
		end
	endfunction

	function automatic logic [smvc_pkg::MIN_W-1:0] step_min(
		input logic [smvc_pkg::MIN_W-1:0] v, input logic inc);
		begin
			if (inc)
				step_min = (v == smvc_pkg::MIN_LAST) ? '0 : v + 6'd1;
			else
				step_min = (v == '0) ? smvc_pkg::MIN_LAST : v - 6'd1;
		end
	endfunction

	always_comb begin
		mode_nxt  = mode_q;
		hour1_nxt = hour1_q;
		hour2_nxt = hour2_q;
		min1_nxt  = min1_q;
		min2_nxt  = min2_q;
		if (ev.fire && ev.req == smvc_pkg::REQ_MODE) begin
			case (mode_q)
				smvc_pkg::MODE_NORMAL:   mode_nxt = smvc_pkg::MODE_HOUR_ONE;
				smvc_pkg::MODE_HOUR_ONE: mode_nxt = smvc_pkg::MODE_HOUR_TWO;
				smvc_pkg::MODE_HOUR_TWO: mode_nxt = smvc_pkg::MODE_MIN_ONE;
				smvc_pkg::MODE_MIN_ONE:  mode_nxt = smvc_pkg::MODE_MIN_TWO;
				default:                 mode_nxt = smvc_pkg::MODE_NORMAL;
			endcase
		end else if (ev.fire && (up || down)) begin
			case (mode_q)
				smvc_pkg::MODE_HOUR_ONE: hour1_nxt = step_hour(hour1_q, up);
				smvc_pkg::MODE_HOUR_TWO: hour2_nxt = step_hour(hour2_q, up);
				smvc_pkg::MODE_MIN_ONE:  min1_nxt  = step_min(min1_q, up);
				smvc_pkg::MODE_MIN_TWO:  min2_nxt  = step_min(min2_q, up);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= smvc_pkg::MODE_NORMAL;
			hour1_q <= smvc_pkg::HOUR1_RESET;
			hour2_q <= smvc_pkg::HOUR2_RESET;
			min1_q  <= '0;
			min2_q  <= '0;
		end else begin
			mode_q  <= mode_nxt;
			hour1_q <= hour1_nxt;
			hour2_q <= hour2_nxt;
			min1_q  <= min1_nxt;
			min2_q  <= min2_nxt;
		end
	end

	// The schedule is compared in BCD, so invalid clock digits never match.
	assign h1_bcd  = smvc_pkg::to_bcd({1'b0, hour1_q});
	assign h2_bcd  = smvc_pkg::to_bcd({1'b0, hour2_q});
	assign m1_bcd  = smvc_pkg::to_bcd(min1_q);
	assign m2_bcd  = smvc_pkg::to_bcd(min2_q);
	assign hour_in = {1'b0, ev.hour_bcd};

	assign sts.match = (hour_in == h1_bcd && ev.minute_bcd == m1_bcd) ||
			   (hour_in == h2_bcd && ev.minute_bcd == m2_bcd);
	assign sts.mode  = mode_nxt;

	always_comb begin
		case (mode_nxt)
			smvc_pkg::MODE_HOUR_ONE: sts.value = {1'b0, hour1_nxt};
			smvc_pkg::MODE_HOUR_TWO: sts.value = {1'b0, hour2_nxt};
			smvc_pkg::MODE_MIN_ONE:  sts.value = min1_nxt;
			smvc_pkg::MODE_MIN_TWO:  sts.value = min2_nxt;
			default:                 sts.value = '0;
		endcase
	end

	ap_hour1_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour1_q <= smvc_pkg::HOUR_LAST && hour2_q <= smvc_pkg::HOUR_LAST)
		else $error("schedule hour left its range");

	ap_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min1_q <= smvc_pkg::MIN_LAST && min2_q <= smvc_pkg::MIN_LAST)
		else $error("schedule minute left its range");

	ap_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ev.fire |=> $stable(mode_q) && $stable(hour1_q) && $stable(min2_q))
		else $error("schedule state moved without an event");

endmodule

// File: hw/rtl/scheduled_moisture_valve_controller.sv
// Channel  Signals                                            Direction
// input    in_valid, in_ready, req_type, clock_hour_bcd,     into block
//          clock_minute_bcd, moisture_sample
// output   out_valid, out_ready, valve_open, moisture_pct,    out of block
//          edit_mode, edit_value
// config   cfg_valid, cfg_ready, cfg_index, cfg_data          into block
//
// Each accepted word is held first in the input register, then takes a single
// pass of logic into the result register.
// One word is accepted every cycle when the output side keeps taking results.
// Reset is asynchronous; thresholds, schedules, mode and valve return to their
// initial values at once. Configuration writes are always taken.
// A stalled output holds its result while an empty input register still takes one
// more word; after that in_ready falls until the result is taken.
module scheduled_moisture_valve_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [smvc_pkg::HOUR_BCD_W-1:0]    clock_hour_bcd,
	input  logic [smvc_pkg::MIN_BCD_W-1:0]     clock_minute_bcd,
	input  logic [smvc_pkg::SAMPLE_W-1:0]      moisture_sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               valve_open,
	output logic [smvc_pkg::PCT_W-1:0]         moisture_pct,
	output logic [2:0]                         edit_mode,
	output logic [smvc_pkg::MIN_W-1:0]         edit_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [smvc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smvc_pkg::LEVEL_W-1:0]       cfg_data
);

	// Threshold registers.
	logic [smvc_pkg::LEVEL_W-1:0] crit_q, good_q;

	// Input register holding the word being processed.
	logic                              valid_s1;
	smvc_pkg::req_t                    req_s1;
	logic [smvc_pkg::HOUR_BCD_W-1:0]   hour_s1;
	logic [smvc_pkg::MIN_BCD_W-1:0]    minute_s1;
	logic [smvc_pkg::SAMPLE_W-1:0]     sample_s1;

	// Valve and moisture state, which also feed the result directly.
	logic                        valve_q;
	logic [smvc_pkg::PCT_W-1:0]  moist_q;

	// Result register.
	logic                        out_valid_q;
	logic [2:0]                  mode_out_q;
	logic [smvc_pkg::MIN_W-1:0]  value_out_q;

	logic                        adv;
	logic                        is_check;
	logic [smvc_pkg::PCT_W-1:0]  pct;
	logic                        valve_nxt;
	logic [smvc_pkg::PCT_W-1:0]  moist_nxt;
	smvc_pkg::sched_ev_t         ev;
	smvc_pkg::sched_sts_t        sts;

	// The staged word moves on whenever the result register is empty or being
	// emptied; the input register refills in the same cycle.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q <= smvc_pkg::CRIT_RESET;
			good_q <= smvc_pkg::GOOD_RESET;
		end else if (cfg_valid) begin
			case (smvc_pkg::cfg_idx_t'(cfg_index))
				smvc_pkg::CFG_CRITICAL: crit_q <= cfg_data;
				smvc_pkg::CFG_GOOD:     good_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1    <= smvc_pkg::req_t'(req_type);
			hour_s1   <= clock_hour_bcd;
			minute_s1 <= clock_minute_bcd;
			sample_s1 <= moisture_sample;
		end
	end

	assign is_check = req_s1 == smvc_pkg::REQ_CHECK;

	assign ev.fire       = adv;
	assign ev.req        = req_s1;
	assign ev.hour_bcd   = hour_s1;
	assign ev.minute_bcd = minute_s1;

	smvc_pct u_pct (
		.sample (sample_s1),
		.pct    (pct)
	);

	smvc_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.sts    (sts)
	);

	// A check tick refreshes the percentage and decides the valve; button words
	// leave both untouched.
	always_comb begin
		moist_nxt = moist_q;
		valve_nxt = valve_q;
		if (adv && is_check) begin
			moist_nxt = pct;
			valve_nxt = (pct < crit_q) || (sts.match && pct < good_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q     <= 1'b0;
			moist_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valve_q <= valve_nxt;
			moist_q <= moist_nxt;
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_out_q  <= sts.mode;
			value_out_q <= sts.value;
		end
	end

	assign out_valid    = out_valid_q;
	assign valve_open   = valve_q;
	assign moisture_pct = moist_q;
	assign edit_mode    = mode_out_q;
	assign edit_value   = value_out_q;

	ap_normal_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mode_out_q == smvc_pkg::MODE_NORMAL |-> value_out_q == '0)
		else $error("edit value not zero in normal mode");

	ap_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		moist_q <= smvc_pkg::PCT_FULL)
		else $error("moisture percentage above one hundred");

	ap_button_keeps_valve: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !is_check |=> $stable(valve_q) && $stable(moist_q))
		else $error("button word changed valve or moisture");

	ap_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1) && $stable(sample_s1))
		else $error("staged word lost during a stall");

endmodule
